// ===== design/rgb_block_average_to_xterm256_defines.svh =====
// Assertion macros for the checker file of this block.
`ifndef RGB_BLOCK_AVERAGE_TO_XTERM256_DEFINES_SVH
`define RGB_BLOCK_AVERAGE_TO_XTERM256_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBAX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rbax check failed");

// The consequent must hold in the cycle after the antecedent.
`define RBAX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rbax check failed");

`endif

// ===== design/rbax_pkg.sv =====
package rbax_pkg;

    localparam int IMAGE_WIDTH  = 256;
    localparam int IMAGE_HEIGHT = 256;
    localparam int CELL_WIDTH   = 4;
    localparam int HALF_HEIGHT  = 4;

    localparam int CELL_HEIGHT = 2 * HALF_HEIGHT;
    localparam int CELL_COLS   = (IMAGE_WIDTH + CELL_WIDTH - 1) / CELL_WIDTH;
    localparam int CELL_ROWS   = (IMAGE_HEIGHT + CELL_HEIGHT - 1) / CELL_HEIGHT;

    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = $clog2(IMAGE_HEIGHT);
    localparam int CX_W  = (CELL_WIDTH > 1) ? $clog2(CELL_WIDTH) : 1;
    localparam int RY_W  = $clog2(CELL_HEIGHT);
    localparam int CC_W  = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1;

    localparam int HALF_PIXELS = CELL_WIDTH * HALF_HEIGHT;
    localparam int SUM_W       = $clog2(255 * HALF_PIXELS + 1);
    localparam int DIV_W       = $clog2(HALF_PIXELS + 1);
    localparam int DIV_K       = SUM_W + DIV_W;
    localparam int REC_W       = DIV_K + 1;

    // Clipped cells at the right edge and in the bottom band of cells.
    localparam int LAST_W        = IMAGE_WIDTH - (CELL_COLS - 1) * CELL_WIDTH;
    localparam int LAST_BAND_ROW = (CELL_ROWS - 1) * CELL_HEIGHT;
    localparam int LAST_BAND_H   = IMAGE_HEIGHT - LAST_BAND_ROW;
    localparam int UP_LAST = (LAST_BAND_H < HALF_HEIGHT) ? LAST_BAND_H : HALF_HEIGHT;
    localparam int LO_LAST = (LAST_BAND_H > HALF_HEIGHT) ? LAST_BAND_H - HALF_HEIGHT : 0;

    localparam int CNT_UP_FULL   = CELL_WIDTH * HALF_HEIGHT;
    localparam int CNT_UP_EDGE_X = LAST_W * HALF_HEIGHT;
    localparam int CNT_UP_EDGE_Y = CELL_WIDTH * UP_LAST;
    localparam int CNT_UP_CORNER = LAST_W * UP_LAST;
    localparam int CNT_LO_FULL   = CELL_WIDTH * HALF_HEIGHT;
    localparam int CNT_LO_EDGE_X = LAST_W * HALF_HEIGHT;
    localparam int CNT_LO_EDGE_Y = CELL_WIDTH * LO_LAST;
    localparam int CNT_LO_CORNER = LAST_W * LO_LAST;

    // Reciprocals for exact division of a half sum by its pixel count.
    // A half with no pixels has a zero sum, so its reciprocal is zero.
    localparam int REC_UP_FULL = (CNT_UP_FULL == 0) ? 0 :
        (2 ** DIV_K + CNT_UP_FULL - 1) / ((CNT_UP_FULL == 0) ? 1 : CNT_UP_FULL);
    localparam int REC_UP_EDGE_X = (CNT_UP_EDGE_X == 0) ? 0 :
        (2 ** DIV_K + CNT_UP_EDGE_X - 1) / ((CNT_UP_EDGE_X == 0) ? 1 : CNT_UP_EDGE_X);
    localparam int REC_UP_EDGE_Y = (CNT_UP_EDGE_Y == 0) ? 0 :
        (2 ** DIV_K + CNT_UP_EDGE_Y - 1) / ((CNT_UP_EDGE_Y == 0) ? 1 : CNT_UP_EDGE_Y);
    localparam int REC_UP_CORNER = (CNT_UP_CORNER == 0) ? 0 :
        (2 ** DIV_K + CNT_UP_CORNER - 1) / ((CNT_UP_CORNER == 0) ? 1 : CNT_UP_CORNER);
    localparam int REC_LO_FULL = (CNT_LO_FULL == 0) ? 0 :
        (2 ** DIV_K + CNT_LO_FULL - 1) / ((CNT_LO_FULL == 0) ? 1 : CNT_LO_FULL);
    localparam int REC_LO_EDGE_X = (CNT_LO_EDGE_X == 0) ? 0 :
        (2 ** DIV_K + CNT_LO_EDGE_X - 1) / ((CNT_LO_EDGE_X == 0) ? 1 : CNT_LO_EDGE_X);
    localparam int REC_LO_EDGE_Y = (CNT_LO_EDGE_Y == 0) ? 0 :
        (2 ** DIV_K + CNT_LO_EDGE_Y - 1) / ((CNT_LO_EDGE_Y == 0) ? 1 : CNT_LO_EDGE_Y);
    localparam int REC_LO_CORNER = (CNT_LO_CORNER == 0) ? 0 :
        (2 ** DIV_K + CNT_LO_CORNER - 1) / ((CNT_LO_CORNER == 0) ? 1 : CNT_LO_CORNER);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_rgb_sum;

    localparam int RGB_SUM_W = $bits(t_rgb_sum);

    typedef struct packed {
        t_rgb_sum         upper;
        t_rgb_sum         lower;
        logic [REC_W-1:0] upper_rec;
        logic [REC_W-1:0] lower_rec;
        logic [CC_W-1:0]  cc;
        logic             row_end;
    } t_cell;

    typedef struct packed {
        logic  valid;
        t_cell entry;
    } t_qpush;

endpackage

// ===== design/rbax_pixel_if.sv =====
interface rbax_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== design/rbax_cell_if.sv =====
interface rbax_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] top_color;
    logic [7:0] bottom_color;
    logic [5:0] cell_column;
    logic       row_end;

    modport source (output valid, top_color, bottom_color, cell_column, row_end, input ready);
    modport sink (input valid, top_color, bottom_color, cell_column, row_end, output ready);
endinterface

// ===== design/rbax_ram.sv =====
module rbax_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rbax_front.sv =====
module rbax_front
    import rbax_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbax_pixel_if.sink i_pixel,
    input  logic       i_queue_full,
    output t_qpush     o_push
);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CX_W-1:0]  r_cx;
    logic [CC_W-1:0]  r_cc;
    logic [RY_W-1:0]  r_ry;
    t_rgb_sum         r_seg;

    logic             r_s2_valid;
    t_rgb_sum         r_s2_seg;
    logic [CC_W-1:0]  r_s2_cc;
    logic             r_s2_upper;
    logic             r_s2_first;
    logic             r_s2_cell_end;
    logic             r_s2_row_end;
    logic             r_s2_edge_x;
    logic             r_s2_edge_y;

    logic             accept;
    logic             last_col;
    logic             last_row;
    logic             last_x;
    logic             last_y;
    logic             upper;
    logic             first_row;
    logic             s2_adv;
    logic             rd_en;
    t_rgb_sum         base;
    t_rgb_sum         n_seg;
    t_rgb_sum         up_rdata;
    t_rgb_sum         lo_rdata;
    t_rgb_sum         prev;
    t_rgb_sum         total;
    logic [REC_W-1:0] up_rec;
    logic [REC_W-1:0] lo_rec;

    assign i_pixel.ready = !r_s2_valid || !r_s2_cell_end || !i_queue_full;
    assign accept        = i_pixel.valid && i_pixel.ready;
    assign s2_adv        = r_s2_valid && (!r_s2_cell_end || !i_queue_full);

    assign last_col  = r_col == COL_W'(IMAGE_WIDTH - 1);
    assign last_row  = r_row == ROW_W'(IMAGE_HEIGHT - 1);
    assign last_x    = (r_cx == CX_W'(CELL_WIDTH - 1)) || last_col;
    assign last_y    = (r_ry == RY_W'(CELL_HEIGHT - 1)) || last_row;
    assign upper     = r_ry < RY_W'(HALF_HEIGHT);
    assign first_row = (r_ry == '0) || (r_ry == RY_W'(HALF_HEIGHT));
    assign rd_en     = accept && last_x;

    // Each cell row segment is summed here; the stored half sum is added once it ends.
    always_comb begin
        base    = (r_cx == '0) ? '0 : r_seg;
        n_seg.r = base.r + SUM_W'(i_pixel.red);
        n_seg.g = base.g + SUM_W'(i_pixel.green);
        n_seg.b = base.b + SUM_W'(i_pixel.blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_cx       <= '0;
            r_cc       <= '0;
            r_ry       <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_cx  <= '0;
                    r_cc  <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                    r_ry  <= (last_row || (r_ry == RY_W'(CELL_HEIGHT - 1))) ? '0 : r_ry + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                    if (r_cx == CX_W'(CELL_WIDTH - 1)) begin
                        r_cx <= '0;
                        r_cc <= r_cc + 1'b1;
                    end else begin
                        r_cx <= r_cx + 1'b1;
                    end
                end
            end
            if (accept) begin
                r_s2_valid <= last_x;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seg <= n_seg;
            if (last_x) begin
                r_s2_seg      <= n_seg;
                r_s2_cc       <= r_cc;
                r_s2_upper    <= upper;
                r_s2_first    <= first_row;
                r_s2_cell_end <= last_y;
                r_s2_row_end  <= last_col;
                r_s2_edge_x   <= r_cc == CC_W'(CELL_COLS - 1);
                r_s2_edge_y   <= r_row >= ROW_W'(LAST_BAND_ROW);
            end
        end
    end

    rbax_ram #(
        .WIDTH (RGB_SUM_W),
        .DEPTH (CELL_COLS)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (s2_adv && r_s2_upper),
        .i_waddr (r_s2_cc),
        .i_wdata (total),
        .i_re    (rd_en),
        .i_raddr (r_cc),
        .o_rdata (up_rdata)
    );

    rbax_ram #(
        .WIDTH (RGB_SUM_W),
        .DEPTH (CELL_COLS)
    ) u_lower_ram (
        .i_clk   (i_clk),
        .i_we    (s2_adv && !r_s2_upper),
        .i_waddr (r_s2_cc),
        .i_wdata (total),
        .i_re    (rd_en),
        .i_raddr (r_cc),
        .o_rdata (lo_rdata)
    );

    always_comb begin
        prev    = r_s2_upper ? up_rdata : lo_rdata;
        total.r = r_s2_first ? r_s2_seg.r : r_s2_seg.r + prev.r;
        total.g = r_s2_first ? r_s2_seg.g : r_s2_seg.g + prev.g;
        total.b = r_s2_first ? r_s2_seg.b : r_s2_seg.b + prev.b;
    end

    always_comb begin
        unique case ({r_s2_edge_x, r_s2_edge_y})
            2'b00: begin
                up_rec = REC_W'(REC_UP_FULL);
                lo_rec = REC_W'(REC_LO_FULL);
            end
            2'b10: begin
                up_rec = REC_W'(REC_UP_EDGE_X);
                lo_rec = REC_W'(REC_LO_EDGE_X);
            end
            2'b01: begin
                up_rec = REC_W'(REC_UP_EDGE_Y);
                lo_rec = REC_W'(REC_LO_EDGE_Y);
            end
            default: begin
                up_rec = REC_W'(REC_UP_CORNER);
                lo_rec = REC_W'(REC_LO_CORNER);
            end
        endcase
    end

    // A cell that ends inside its upper half has an empty lower half.
    always_comb begin
        o_push.valid           = s2_adv && r_s2_cell_end;
        o_push.entry.upper     = r_s2_upper ? total : up_rdata;
        o_push.entry.lower     = r_s2_upper ? '0 : total;
        o_push.entry.upper_rec = up_rec;
        o_push.entry.lower_rec = lo_rec;
        o_push.entry.cc        = r_s2_cc;
        o_push.entry.row_end   = r_s2_row_end;
    end

endmodule

// ===== design/rbax_queue.sv =====
module rbax_queue
    import rbax_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qpush i_push,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_cell  o_cell
);

    t_cell             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_full  = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cell  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

endmodule

// ===== design/rbax_back.sv =====
module rbax_back
    import rbax_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_cell        i_cell,
    output logic         o_pop,
    rbax_cell_if.source  o_cell
);

    localparam int GREY_SPREAD   = 10;
    localparam int GREY_LOW      = 8;
    localparam int GREY_HIGH     = 248;
    localparam int GREY_CUBE_TOP = 231;
    localparam int GREY_BASE     = 232;
    localparam int CUBE_BASE     = 16;
    localparam int CUBE_R_STEP   = 36;
    localparam int CUBE_G_STEP   = 6;
    localparam int MAX_INDEX     = 255;
    localparam int DIV3_MUL      = 1366;
    localparam int DIV3_SHIFT    = 12;
    localparam int DIV10_MUL     = 410;
    localparam int DIV10_SHIFT   = 12;
    localparam int PROD_W        = SUM_W + REC_W;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb8;

    typedef struct packed {
        logic       grey;
        logic [7:0] gr;
        logic [2:0] dr;
        logic [2:0] dg;
        logic [2:0] db;
    } t_map;

    function automatic logic [7:0] div_count(input logic [SUM_W-1:0] s,
                                             input logic [REC_W-1:0] m);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(m);
        return p[DIV_K +: 8];
    endfunction

    function automatic logic [2:0] cube_digit(input logic [7:0] v);
        logic [2:0] d;
        if (v == 8'd255) begin
            d = 3'd5;
        end else if (v >= 8'd204) begin
            d = 3'd4;
        end else if (v >= 8'd153) begin
            d = 3'd3;
        end else if (v >= 8'd102) begin
            d = 3'd2;
        end else if (v >= 8'd51) begin
            d = 3'd1;
        end else begin
            d = 3'd0;
        end
        return d;
    endfunction

    function automatic t_map map_front(input t_rgb8 c);
        t_map        m;
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [9:0]  s3;
        logic [20:0] p;
        mx = (c.r > c.g) ? ((c.r > c.b) ? c.r : c.b) : ((c.g > c.b) ? c.g : c.b);
        mn = (c.r < c.g) ? ((c.r < c.b) ? c.r : c.b) : ((c.g < c.b) ? c.g : c.b);
        s3 = 10'(c.r) + 10'(c.g) + 10'(c.b);
        p = 21'(s3) * 21'(DIV3_MUL);
        m.grey = (mx - mn) < 8'(GREY_SPREAD);
        m.gr   = p[DIV3_SHIFT +: 8];
        m.dr   = cube_digit(c.r);
        m.dg   = cube_digit(c.g);
        m.db   = cube_digit(c.b);
        return m;
    endfunction

    function automatic logic [7:0] map_back(input t_map m);
        logic [7:0]  x;
        logic [16:0] p;
        logic [8:0]  g;
        logic [7:0]  idx;
        x = m.gr - 8'(GREY_LOW);
        p = 17'(x) * 17'(DIV10_MUL);
        g = 9'(GREY_BASE) + 9'(p[DIV10_SHIFT +: 5]);
        if (m.grey) begin
            if (m.gr < 8'(GREY_LOW)) begin
                idx = 8'(CUBE_BASE);
            end else if (m.gr > 8'(GREY_HIGH)) begin
                idx = 8'(GREY_CUBE_TOP);
            end else if (g > 9'(MAX_INDEX)) begin
                idx = 8'(MAX_INDEX);
            end else begin
                idx = g[7:0];
            end
        end else begin
            idx = 8'(CUBE_BASE) + 8'(m.dr) * 8'(CUBE_R_STEP) + 8'(m.dg) * 8'(CUBE_G_STEP)
                + 8'(m.db);
        end
        return idx;
    endfunction

    logic       adv;
    logic       r_d_valid;
    t_rgb8      r_d_up;
    t_rgb8      r_d_lo;
    logic [5:0] r_d_cc;
    logic       r_d_row_end;
    logic       r_m_valid;
    t_map       r_m_up;
    t_map       r_m_lo;
    logic [5:0] r_m_cc;
    logic       r_m_row_end;
    logic       r_out_valid;
    logic [7:0] r_out_top;
    logic [7:0] r_out_bottom;
    logic [5:0] r_out_cc;
    logic       r_out_row_end;
    t_rgb8      n_up;
    t_rgb8      n_lo;

    assign adv   = !r_out_valid || o_cell.ready;
    assign o_pop = adv && i_valid;

    always_comb begin
        n_up.r = div_count(i_cell.upper.r, i_cell.upper_rec);
        n_up.g = div_count(i_cell.upper.g, i_cell.upper_rec);
        n_up.b = div_count(i_cell.upper.b, i_cell.upper_rec);
        n_lo.r = div_count(i_cell.lower.r, i_cell.lower_rec);
        n_lo.g = div_count(i_cell.lower.g, i_cell.lower_rec);
        n_lo.b = div_count(i_cell.lower.b, i_cell.lower_rec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_d_valid   <= i_valid;
            r_m_valid   <= r_d_valid;
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_up        <= n_up;
            r_d_lo        <= n_lo;
            r_d_cc        <= 6'(i_cell.cc);
            r_d_row_end   <= i_cell.row_end;
            r_m_up        <= map_front(r_d_up);
            r_m_lo        <= map_front(r_d_lo);
            r_m_cc        <= r_d_cc;
            r_m_row_end   <= r_d_row_end;
            r_out_top     <= map_back(r_m_up);
            r_out_bottom  <= map_back(r_m_lo);
            r_out_cc      <= r_m_cc;
            r_out_row_end <= r_m_row_end;
        end
    end

    assign o_cell.valid        = r_out_valid;
    assign o_cell.top_color    = r_out_top;
    assign o_cell.bottom_color = r_out_bottom;
    assign o_cell.cell_column  = r_out_cc;
    assign o_cell.row_end      = r_out_row_end;

endmodule

// ===== design/rgb_block_average_to_xterm256.sv =====
// Takes one RGB pixel request per clock in raster order over a 256 by 256 frame and returns
// one request per completed 4-wide by 8-tall text cell, carrying the xterm-256 indices of the
// upper and lower 4 by 4 half averages, the cell column and a row end flag. Pixels are taken
// back to back; when the output is free, a cell result goes from stage two through the queue
// and the divide, map and output registers. Per-column half sums live in two 64-entry RAMs
// whose registered read is issued on the last pixel of each cell row segment and then added
// to the segment sum. A four-entry queue decouples the pixel side from the color mapping
// pipeline, so the pixel ready drops only when that queue is full and another cell completes.
// The sum RAMs need no clearing after reset, since every half sum restarts on the first row of its half.
module rgb_block_average_to_xterm256
    import rbax_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbax_pixel_if.sink  i_pixel,
    rbax_cell_if.source o_cell
);

    t_qpush push;
    logic   queue_full;
    logic   queue_valid;
    logic   queue_pop;
    t_cell  queue_cell;

    rbax_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pixel      (i_pixel),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    rbax_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (queue_pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cell  (queue_cell)
    );

    rbax_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_cell  (queue_cell),
        .o_pop   (queue_pop),
        .o_cell  (o_cell)
    );

endmodule

// ===== design/rbax_checker.sv =====
`include "rgb_block_average_to_xterm256_defines.svh"

module rbax_checker
    import rbax_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_top_color,
    input logic [7:0] i_bottom_color,
    input logic [5:0] i_cell_column,
    input logic       i_row_end
);

    logic in_accept;

    assign in_accept = i_in_valid && i_in_ready;

    // A stalled result request keeps its contents.
    `RBAX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_top_color) && $stable(i_bottom_color) && $stable(i_cell_column) && $stable(i_row_end))

    // The mapping never lands in the sixteen system colors.
    `RBAX_ASSERT_NOW(a_color_range, i_clk, i_rst_n, i_out_valid, (i_top_color >= 8'd16) && (i_bottom_color >= 8'd16))

    // Only the rightmost cell closes a row of cells.
    `RBAX_ASSERT_NOW(a_row_end_column, i_clk, i_rst_n, i_out_valid && i_row_end, i_cell_column == 6'(CELL_COLS - 1))

    // No result can be pending right after reset, and no pixel can complete a cell that early.
    `RBAX_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n) || ($past(!i_rst_n, 2) && !$past(in_accept)), !i_out_valid)

endmodule

bind rgb_block_average_to_xterm256 rbax_checker u_rbax_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pixel.valid),
    .i_in_ready     (i_pixel.ready),
    .i_out_valid    (o_cell.valid),
    .i_out_ready    (o_cell.ready),
    .i_top_color    (o_cell.top_color),
    .i_bottom_color (o_cell.bottom_color),
    .i_cell_column  (o_cell.cell_column),
    .i_row_end      (o_cell.row_end)
);

// ===== dv/rgb_block_average_to_xterm256_check.sv =====
`timescale 1ns / 100ps

module rgb_block_average_to_xterm256_check
    import rbax_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    rbax_pixel_if i_pixel,
    rbax_cell_if  i_cell,
    output int    o_mismatches,
    output int    o_cells_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        int unsigned r;
        int unsigned g;
        int unsigned b;
    } rgb_total_t;

    typedef struct {
        logic [7:0] top_color;
        logic [7:0] bottom_color;
        logic [5:0] cell_column;
        logic       row_end;
    } cell_colors_t;

    rgb_total_t   upper_total [CELL_COLS];
    rgb_total_t   lower_total [CELL_COLS];
    int unsigned  pixel_col;
    int unsigned  pixel_row;
    cell_colors_t expected_cells [$];

    // Averages a half block and maps it onto the grey ramp or the 6x6x6 color cube.
    function automatic logic [7:0] half_index(rgb_total_t total, int unsigned count);
        int unsigned r, g, b, hi, lo, grey, idx;
        r = (count == 0) ? 0 : total.r / count;
        g = (count == 0) ? 0 : total.g / count;
        b = (count == 0) ? 0 : total.b / count;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        if (hi - lo < 10) begin
            grey = (r + g + b) / 3;
            if (grey < 8) begin
                return 8'd16;
            end
            if (grey > 248) begin
                return 8'd231;
            end
            idx = 232 + (grey - 8) * 24 / 240;
            return (idx > 255) ? 8'd255 : idx[7:0];
        end
        idx = 16 + 36 * (r * 5 / 255) + 6 * (g * 5 / 255) + b * 5 / 255;
        return idx[7:0];
    endfunction

    always @(posedge i_clk) begin : predict
        cell_colors_t got;
        cell_colors_t want;
        int unsigned  cc, cx, ry, row0, width, rows_left, up_rows, lo_rows;
        logic         last_x, last_y;
        if (!i_rst_n) begin
            pixel_col = 0;
            pixel_row = 0;
            expected_cells.delete();
        end else begin
            if (i_cell.valid && i_cell.ready) begin
                got = '{i_cell.top_color, i_cell.bottom_color, i_cell.cell_column,
                        i_cell.row_end};
                if (expected_cells.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= MAX_REPORTS) begin
                        $display("%t: unexpected cell request: top %0d bottom %0d column %0d end %0b",
                                 $realtime, got.top_color, got.bottom_color, got.cell_column,
                                 got.row_end);
                    end
                end else begin
                    want = expected_cells.pop_front();
                    if (got.top_color != want.top_color
                            || got.bottom_color != want.bottom_color
                            || got.cell_column != want.cell_column
                            || got.row_end != want.row_end) begin
                        o_mismatches++;
                        if (o_mismatches <= MAX_REPORTS) begin
                            $display("%t: cell mismatch: expected top %0d bottom %0d column %0d end %0b, got top %0d bottom %0d column %0d end %0b",
                                     $realtime, want.top_color, want.bottom_color,
                                     want.cell_column, want.row_end, got.top_color,
                                     got.bottom_color, got.cell_column, got.row_end);
                        end
                    end
                end
            end

            if (i_pixel.valid && i_pixel.ready) begin
                cc = pixel_col / CELL_WIDTH;
                cx = pixel_col % CELL_WIDTH;
                ry = pixel_row % CELL_HEIGHT;
                if (cc >= CELL_COLS) begin
                    cc = CELL_COLS - 1;
                end
                // A half restarts on its first pixel; the top row of a cell clears both halves.
                if (cx == 0 && ry == 0) begin
                    upper_total[cc] = '{0, 0, 0};
                    lower_total[cc] = '{0, 0, 0};
                end
                if (cx == 0 && ry == HALF_HEIGHT) begin
                    lower_total[cc] = '{0, 0, 0};
                end
                if (ry < HALF_HEIGHT) begin
                    upper_total[cc].r += i_pixel.red;
                    upper_total[cc].g += i_pixel.green;
                    upper_total[cc].b += i_pixel.blue;
                end else begin
                    lower_total[cc].r += i_pixel.red;
                    lower_total[cc].g += i_pixel.green;
                    lower_total[cc].b += i_pixel.blue;
                end

                last_x = (cx == CELL_WIDTH - 1) || (pixel_col == IMAGE_WIDTH - 1);
                last_y = (ry == CELL_HEIGHT - 1) || (pixel_row == IMAGE_HEIGHT - 1);
                if (last_x && last_y) begin
                    row0 = pixel_row - ry;
                    width = IMAGE_WIDTH - cc * CELL_WIDTH;
                    width = (width < CELL_WIDTH) ? width : CELL_WIDTH;
                    rows_left = IMAGE_HEIGHT - row0;
                    up_rows = (rows_left < HALF_HEIGHT) ? rows_left : HALF_HEIGHT;
                    lo_rows = (rows_left > HALF_HEIGHT) ? rows_left - HALF_HEIGHT : 0;
                    lo_rows = (lo_rows < HALF_HEIGHT) ? lo_rows : HALF_HEIGHT;
                    want.top_color = half_index(upper_total[cc], width * up_rows);
                    want.bottom_color = half_index(lower_total[cc], width * lo_rows);
                    want.cell_column = cc[5:0];
                    want.row_end = (pixel_col == IMAGE_WIDTH - 1);
                    expected_cells.push_back(want);
                end

                if (pixel_col + 1 >= IMAGE_WIDTH) begin
                    pixel_col = 0;
                    pixel_row = (pixel_row + 1 >= IMAGE_HEIGHT) ? 0 : pixel_row + 1;
                end else begin
                    pixel_col = pixel_col + 1;
                end
            end
            o_cells_pending = expected_cells.size();
        end
    end

endmodule

// ===== dv/rgb_block_average_to_xterm256_test.sv =====
`timescale 1ns / 100ps

module rgb_block_average_to_xterm256_test;
    import rbax_pkg::*;

    // One full band of cells, so that every cell column completes once.
    localparam int PIXELS_TOTAL = IMAGE_WIDTH * CELL_HEIGHT;
    // The long output stall starts early in the last row of the band of cells.
    localparam int HOLD_START   = (CELL_HEIGHT - 1) * IMAGE_WIDTH + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int NOISE_SPREAD = 256;
    localparam int SHADE_COUNT  = 16;

    typedef enum int {
        SHADE_NOISE,
        SHADE_GREY,
        SHADE_GREY_TOP,
        SHADE_GREY_EDGE,
        SHADE_CUBE,
        SHADE_EXTREME
    } t_shade_kind;

    // Red, green, blue and spread of the halves in the leftmost cells of each band.
    int directed_shade [SHADE_COUNT][4] = '{
        '{0, 0, 0, 0},
        '{255, 255, 255, 0},
        '{248, 248, 248, 0},
        '{249, 249, 249, 0},
        '{247, 247, 247, 0},
        '{8, 8, 8, 0},
        '{7, 7, 7, 0},
        '{255, 0, 0, 0},
        '{0, 255, 0, 0},
        '{0, 0, 255, 0},
        '{100, 109, 104, 0},
        '{100, 110, 104, 0},
        '{51, 102, 153, 0},
        '{50, 101, 152, 0},
        '{128, 128, 128, 8},
        '{0, 0, 0, NOISE_SPREAD}
    };

    logic        clk;
    logic        rst_n;
    logic        calm;
    logic        hold_off;
    int unsigned recv_wait;
    int          pixels_taken;
    int          mismatches;
    int          cells_pending;
    int          shade_r [CELL_COLS][2];
    int          shade_g [CELL_COLS][2];
    int          shade_b [CELL_COLS][2];
    int          shade_spread [CELL_COLS][2];

    rbax_pixel_if pixel_bus ();
    rbax_cell_if  cell_bus ();

    rgb_block_average_to_xterm256 dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pixel (pixel_bus),
        .o_cell  (cell_bus)
    );

    rgb_block_average_to_xterm256_check checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_pixel         (pixel_bus),
        .i_cell          (cell_bus),
        .o_mismatches    (mismatches),
        .o_cells_pending (cells_pending)
    );

    function automatic logic [7:0] jitter(int level, int spread);
        int v;
        if (spread >= NOISE_SPREAD) begin
            return 8'($urandom_range(0, 255));
        end
        v = level - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v[7:0];
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #1ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        hold_off <= 1'b0;
        wait (pixels_taken >= HOLD_START);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin : cell_sink
        int unsigned gap;
        if (!rst_n) begin
            cell_bus.ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            gap = recv_wait;
            if (cell_bus.valid && cell_bus.ready) begin
                gap = calm ? 0 : $urandom_range(0, 4);
            end
            if (gap != 0) begin
                cell_bus.ready <= 1'b0;
                recv_wait <= gap - 1;
            end else begin
                cell_bus.ready <= !hold_off;
                recv_wait <= 0;
            end
        end
    end

    initial begin : pixel_source
        int unsigned gap, row, col, cc, cx, ry, half, pick;
        int          r, g, b, s, n;
        t_shade_kind kind;
        rst_n <= 1'b0;
        calm <= 1'b0;
        pixel_bus.valid <= 1'b0;
        pixel_bus.red <= '0;
        pixel_bus.green <= '0;
        pixel_bus.blue <= '0;
        pixels_taken = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        gap = $urandom_range(0, 4);

        for (n = 0; n < PIXELS_TOTAL; n++) begin
            if (gap != 0) begin
                pixel_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            row = (n / IMAGE_WIDTH) % IMAGE_HEIGHT;
            col = n % IMAGE_WIDTH;
            cc = col / CELL_WIDTH;
            cx = col % CELL_WIDTH;
            ry = row % CELL_HEIGHT;
            half = (ry >= HALF_HEIGHT) ? 1 : 0;

            // Each half block gets one shade at its first pixel and keeps it for all its rows.
            if (cx == 0 && (ry == 0 || ry == HALF_HEIGHT)) begin
                if (2 * cc + half < SHADE_COUNT) begin
                    pick = 2 * cc + half;
                    r = directed_shade[pick][0];
                    g = directed_shade[pick][1];
                    b = directed_shade[pick][2];
                    s = directed_shade[pick][3];
                end else begin
                    kind = t_shade_kind'($urandom_range(0, 5));
                    r = $urandom_range(0, 255);
                    g = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                    s = 0;
                    case (kind)
                        SHADE_NOISE: begin
                            s = NOISE_SPREAD;
                        end
                        SHADE_GREY: begin
                            g = r;
                            b = r;
                            s = $urandom_range(0, 4);
                        end
                        SHADE_GREY_TOP: begin
                            r = $urandom_range(244, 252);
                            g = r;
                            b = r;
                            s = $urandom_range(0, 1);
                        end
                        SHADE_GREY_EDGE: begin
                            r = $urandom_range(0, 240);
                            g = r + $urandom_range(8, 11);
                            b = r + $urandom_range(0, 11);
                        end
                        SHADE_CUBE: begin
                            s = $urandom_range(0, 24);
                        end
                        SHADE_EXTREME: begin
                            r = $urandom_range(0, 1) * 255;
                            g = $urandom_range(0, 1) * 255;
                            b = $urandom_range(0, 1) * 255;
                        end
                        default: begin
                            s = NOISE_SPREAD;
                        end
                    endcase
                end
                shade_r[cc][half] = r;
                shade_g[cc][half] = g;
                shade_b[cc][half] = b;
                shade_spread[cc][half] = s;
            end

            pixel_bus.valid <= 1'b1;
            pixel_bus.red <= jitter(shade_r[cc][half], shade_spread[cc][half]);
            pixel_bus.green <= jitter(shade_g[cc][half], shade_spread[cc][half]);
            pixel_bus.blue <= jitter(shade_b[cc][half], shade_spread[cc][half]);
            do @(posedge clk); while (!pixel_bus.ready);
            pixels_taken++;
            if (col == IMAGE_WIDTH - 1) begin
                calm <= ($urandom_range(0, 3) == 0);
            end
            gap = calm ? 0 : $urandom_range(0, 4);
        end
        pixel_bus.valid <= 1'b0;

        @(posedge clk);
        wait (cells_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && cells_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/rbax_pkg.sv
design/rbax_pixel_if.sv
design/rbax_cell_if.sv
design/rbax_ram.sv
design/rbax_front.sv
design/rbax_queue.sv
design/rbax_back.sv
design/rgb_block_average_to_xterm256.sv
design/rbax_checker.sv
dv/rgb_block_average_to_xterm256_check.sv
dv/rgb_block_average_to_xterm256_test.sv
